// ===== src/dss_pkg.sv =====
// dss_pkg: shared types and constants for the duplicate stream suppressor
// no dependencies
`default_nettype none
package dss_pkg;
  localparam int unsigned RUN_CAP = 8;
  localparam int unsigned FRAME_GAP_MAX = 3;
  localparam logic [16:0] PRIORITY_BONUS = 17'd100000;
  localparam logic [7:0] COUNT_MAX = 8'd255;
  localparam logic [4:0] OVERLAP_COUNT_MAX = 5'd31;

  localparam logic [2:0] REG_OVERLAP_WINDOW = 3'd0;
  localparam logic [2:0] REG_WEAK_FRAMES = 3'd1;
  localparam logic [2:0] REG_RELEASE_FRAMES = 3'd2;
  localparam logic [2:0] REG_STRONGER_RATIO = 3'd3;
  localparam logic [2:0] REG_STRONGER_DELTA = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRUNE, ST_SCAN, ST_CMP, ST_DECIDE, ST_OUT
  } state_t;

  typedef struct packed {
    logic [15:0] overlap_window;
    logic [7:0]  weak_needed;
    logic [7:0]  release_needed;
    logic [15:0] stronger_ratio;
    logic [15:0] stronger_delta;
  } cfg_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 8'd1;
  endfunction
endpackage
`default_nettype wire

// ===== src/dss_stronger.sv =====
// dss_stronger: clearly-stronger compare, one multiply then registered compare
// depends on dss_pkg
`default_nettype none
module dss_stronger (
  input  wire logic        clk,
  input  wire logic [16:0] score_hi,
  input  wire logic [16:0] score_lo,
  input  wire logic [15:0] ratio,
  input  wire logic [15:0] delta,
  output logic             result_r
);
  import dss_pkg::*;
  logic [32:0] rhs_r;
  logic [24:0] lhs_r;
  logic [17:0] sum_r;
  logic [16:0] strong_r;
  logic        res_nxt;

  always_ff @(posedge clk) begin
    rhs_r <= score_lo * ratio;
    lhs_r <= {score_hi, 8'd0};
    sum_r <= {1'b0, score_lo} + {2'b0, delta};
    strong_r <= score_hi;
    result_r <= res_nxt;
  end

  always_comb begin
    res_nxt = ({8'd0, lhs_r} >= rhs_r) && ({1'b0, strong_r} >= sum_r);
  end
endmodule
`default_nettype wire

// ===== src/duplicate_stream_suppressor_core.sv =====
// duplicate_stream_suppressor_core: top level with sequencer and stream tables
// depends on dss_pkg and dss_stronger
`default_nettype none
// Decides per voice packet word whether to forward or drop it because a
// clearly stronger stream of another session runs in the same channel. One
// sequencer walks the activity table one entry a cycle, twice (stale prune,
// then lookup and overlap scan), then runs one shared multiply/compare,
// decides and updates the session and activity tables, and raises the
// output valid in a last state. Whisper and end-of-stream words take exactly
// the same path. in_ready is low while a word is in work; the result sits in
// an output register and the next word is taken once it is delivered or
// alongside its delivery, so a new word is never taken before the last one
// is through. No clearing pass: tables use valid flops cleared by reset.
module duplicate_stream_suppressor_core #(
  parameter int ACTIVITY_ENTRIES = 16,
  parameter int SESSION_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_session_id,
  input  wire logic [31:0] in_channel_id,
  input  wire logic [31:0] in_timestamp_ms,
  input  wire logic [1:0]  in_codec,
  input  wire logic [11:0] in_payload_size,
  input  wire logic [31:0] in_frame_number,
  input  wire logic        in_is_priority,
  input  wire logic        in_is_terminator,
  input  wire logic        in_is_whisper,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_suppress,
  output logic             out_overlap_seen,
  output logic [4:0]       out_overlap_count,
  output logic             out_has_details,
  output logic [31:0]      out_kept_session,
  output logic [16:0]      out_kept_score,
  output logic [16:0]      out_own_score,
  output logic             out_gate_triggered,
  output logic             out_table_full,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import dss_pkg::*;
  localparam int AW = (ACTIVITY_ENTRIES > 1) ? $clog2(ACTIVITY_ENTRIES) : 1;
  localparam int SW = (SESSION_ENTRIES > 1) ? $clog2(SESSION_ENTRIES) : 1;

  cfg_t cfg_r;

  // activity table
  logic [ACTIVITY_ENTRIES-1:0] act_valid_r;
  logic [31:0] act_session_r [ACTIVITY_ENTRIES];
  logic [31:0] act_channel_r [ACTIVITY_ENTRIES];
  logic [31:0] act_time_r [ACTIVITY_ENTRIES];
  logic [1:0]  act_codec_r [ACTIVITY_ENTRIES];
  logic [31:0] act_frame_r [ACTIVITY_ENTRIES];
  logic [16:0] act_score_r [ACTIVITY_ENTRIES];
  logic [3:0]  act_run_r [ACTIVITY_ENTRIES];
  logic        act_priority_r [ACTIVITY_ENTRIES];

  // session table
  logic [SESSION_ENTRIES-1:0] sess_valid_r;
  logic [31:0] sess_id_r [SESSION_ENTRIES];
  logic [31:0] sess_cand_r [SESSION_ENTRIES];
  logic [7:0]  sess_weak_r [SESSION_ENTRIES];
  logic [7:0]  sess_rel_r [SESSION_ENTRIES];
  logic        sess_muted_r [SESSION_ENTRIES];

  state_t state_r, state_nxt;
  logic [AW-1:0] idx_r;

  // captured input word
  logic [31:0] ses_r, ch_r, now_r, frame_r;
  logic [1:0]  codec_r;
  logic [11:0] size_r;
  logic        prio_r, term_r, whisper_r;

  // scan results
  logic            prev_hit_r, best_hit_r, slot_hit_r;
  logic [AW-1:0]   prev_r, slot_r;
  logic [3:0]      run_r;
  logic [4:0]      count_r;
  logic [16:0]     best_score_r;
  logic [31:0]     best_ses_r;
  logic            best_prio_r;
  logic [1:0]      best_codec_r;
  logic [1:0]      cmp_wait_r;

  // output registers
  logic        out_valid_r;
  logic        o_suppress_r, o_details_r, o_gate_r, o_full_r;
  logic [4:0]  o_count_r;
  logic [31:0] o_kept_ses_r;
  logic [16:0] o_kept_sc_r, o_own_r;

  logic [AW-1:0] ai;
  logic          ent_ch, ent_in_win, cur_done;
  logic [31:0]   tdiff;
  logic [16:0]   own;
  logic          stronger_q;

  assign ai = idx_r;
  assign cur_done = (idx_r == AW'(ACTIVITY_ENTRIES - 1));
  assign tdiff = now_r - act_time_r[ai];
  assign ent_ch = act_valid_r[ai] && (act_channel_r[ai] == ch_r);
  assign ent_in_win = (now_r >= act_time_r[ai]) && (tdiff <= {16'd0, cfg_r.overlap_window});
  assign own = 17'(size_r) + 17'({run_r, 2'b00}) + (prio_r ? PRIORITY_BONUS : 17'd0);

  dss_stronger u_stronger (
    .clk(clk), .score_hi(best_score_r), .score_lo(own),
    .ratio(cfg_r.stronger_ratio), .delta(cfg_r.stronger_delta),
    .result_r(stronger_q)
  );

  logic accept_in;
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept_in = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept_in) state_nxt = ST_PRUNE;
      ST_PRUNE:  if (cur_done) state_nxt = ST_SCAN;
      ST_SCAN:   if (cur_done) state_nxt = ST_CMP;
      ST_CMP:    if (cmp_wait_r == 2'd2) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.overlap_window <= 16'd60;
      cfg_r.weak_needed <= 8'd3;
      cfg_r.release_needed <= 8'd5;
      cfg_r.stronger_ratio <= 16'd320;
      cfg_r.stronger_delta <= 16'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OVERLAP_WINDOW: cfg_r.overlap_window <= cfg_data;
        REG_WEAK_FRAMES:    cfg_r.weak_needed <= cfg_data[7:0];
        REG_RELEASE_FRAMES: cfg_r.release_needed <= cfg_data[7:0];
        REG_STRONGER_RATIO: cfg_r.stronger_ratio <= cfg_data;
        REG_STRONGER_DELTA: cfg_r.stronger_delta <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture word
  always_ff @(posedge clk) begin
    if (accept_in) begin
      ses_r <= in_session_id; ch_r <= in_channel_id; now_r <= in_timestamp_ms;
      codec_r <= in_codec; size_r <= in_payload_size; frame_r <= in_frame_number;
      prio_r <= in_is_priority; term_r <= in_is_terminator; whisper_r <= in_is_whisper;
    end
  end

  // session lookup, combinational over a small table of valid compares
  logic          s_hit, s_free_hit;
  logic [SW-1:0] s_idx, s_free;
  always_comb begin
    s_hit = 1'b0; s_idx = '0; s_free_hit = 1'b0; s_free = '0;
    for (int k = SESSION_ENTRIES - 1; k >= 0; k--) begin
      if (sess_valid_r[k] && sess_id_r[k] == ses_r) begin
        s_hit = 1'b1; s_idx = SW'(k);
      end
      if (!sess_valid_r[k]) begin
        s_free_hit = 1'b1; s_free = SW'(k);
      end
    end
  end

  // hysteresis decision
  logic [31:0] cand, cand_n;
  logic [7:0]  weak_v, weak_n, rel, rel_n;
  logic        muted, muted_n, sup_n, gate_n, det_n, strong_n;
  always_comb begin
    cand = s_hit ? sess_cand_r[s_idx] : 32'd0;
    weak_v = s_hit ? sess_weak_r[s_idx] : 8'd0;
    rel = s_hit ? sess_rel_r[s_idx] : 8'd0;
    muted = s_hit ? sess_muted_r[s_idx] : 1'b0;
    cand_n = 32'd0; weak_n = 8'd0; rel_n = 8'd0; muted_n = 1'b0;
    sup_n = 1'b0; gate_n = 1'b0; det_n = 1'b0;
    strong_n = best_prio_r || (best_codec_r == codec_r && stronger_q);
    if (best_hit_r && !prio_r) begin
      if (strong_n) begin
        if (cand == best_ses_r) begin
          cand_n = cand; weak_n = sat_inc(weak_v); muted_n = muted;
        end else begin
          cand_n = best_ses_r; weak_n = 8'd1; muted_n = 1'b0;
        end
        rel_n = 8'd0;
        if (weak_n >= cfg_r.weak_needed) begin
          gate_n = 1'b1; muted_n = 1'b1; sup_n = 1'b1;
        end
      end else if (muted && cand != 32'd0) begin
        rel_n = sat_inc(rel);
        if (rel_n < cfg_r.release_needed) begin
          sup_n = 1'b1; cand_n = cand; weak_n = weak_v; muted_n = muted;
        end else begin
          rel_n = 8'd0;
        end
      end
      det_n = sup_n || gate_n;
    end else if (muted) begin
      rel_n = sat_inc(rel);
      if (rel_n >= cfg_r.release_needed) rel_n = 8'd0;
      else begin
        cand_n = cand; weak_n = weak_v; muted_n = muted;
      end
    end
  end

  // datapath sequencing
  logic early;
  assign early = whisper_r || term_r || (size_r == 12'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r <= '0;
      sess_valid_r <= '0;
      out_valid_r <= 1'b0;
      idx_r <= '0;
      cmp_wait_r <= '0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          idx_r <= '0;
          prev_hit_r <= 1'b0; best_hit_r <= 1'b0; slot_hit_r <= 1'b0;
          count_r <= '0; run_r <= 4'd1; cmp_wait_r <= '0;
        end
        ST_PRUNE: begin
          // free stale entries of this channel; handle early-exit words
          if (!whisper_r) begin
            if (early) begin
              if (ent_ch && act_session_r[ai] == ses_r) act_valid_r[ai] <= 1'b0;
            end else if (ent_ch && now_r > act_time_r[ai] &&
                         tdiff > {16'd0, cfg_r.overlap_window}) begin
              act_valid_r[ai] <= 1'b0;
            end
          end
          idx_r <= cur_done ? '0 : idx_r + AW'(1);
        end
        ST_SCAN: begin
          if (!act_valid_r[ai] && !slot_hit_r) begin
            slot_hit_r <= 1'b1; slot_r <= ai;
          end
          if (ent_ch && act_session_r[ai] == ses_r && !prev_hit_r) begin
            prev_hit_r <= 1'b1; prev_r <= ai;
            if ((frame_r > act_frame_r[ai] && frame_r - act_frame_r[ai] <= 32'(FRAME_GAP_MAX))
                || ent_in_win)
              run_r <= (act_run_r[ai] >= 4'(RUN_CAP)) ? 4'(RUN_CAP) : act_run_r[ai] + 4'd1;
          end
          if (ent_ch && act_session_r[ai] != ses_r && ent_in_win) begin
            if (count_r != OVERLAP_COUNT_MAX) count_r <= count_r + 5'd1;
            if (!best_hit_r || act_score_r[ai] > best_score_r ||
                (act_score_r[ai] == best_score_r && act_session_r[ai] < best_ses_r)) begin
              best_hit_r <= 1'b1;
              best_score_r <= act_score_r[ai]; best_ses_r <= act_session_r[ai];
              best_prio_r <= act_priority_r[ai]; best_codec_r <= act_codec_r[ai];
            end
          end
          idx_r <= cur_done ? '0 : idx_r + AW'(1);
        end
        ST_CMP: cmp_wait_r <= cmp_wait_r + 2'd1;
        ST_DECIDE: begin
          o_suppress_r <= 1'b0; o_details_r <= 1'b0; o_gate_r <= 1'b0;
          o_full_r <= 1'b0; o_count_r <= '0; o_kept_ses_r <= '0;
          o_kept_sc_r <= '0; o_own_r <= '0;
          if (!whisper_r && early) begin
            if (s_hit) sess_valid_r[s_idx] <= 1'b0;
          end else if (!whisper_r) begin
            o_suppress_r <= sup_n; o_gate_r <= gate_n; o_details_r <= det_n;
            o_count_r <= count_r; o_own_r <= own;
            if (det_n) begin
              o_kept_ses_r <= best_ses_r; o_kept_sc_r <= best_score_r;
            end
            if (!s_hit && !s_free_hit) o_full_r <= 1'b1;
            if (!prev_hit_r && !slot_hit_r) o_full_r <= 1'b1;
            if (!s_hit && s_free_hit) sess_valid_r[s_free] <= 1'b1;
            if (prev_hit_r || slot_hit_r) act_valid_r[prev_hit_r ? prev_r : slot_r] <= 1'b1;
          end
        end
        ST_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // table payload writes
  logic [AW-1:0] wslot;
  logic [SW-1:0] sslot;
  assign wslot = prev_hit_r ? prev_r : slot_r;
  assign sslot = s_hit ? s_idx : s_free;
  always_ff @(posedge clk) begin
    if (state_r == ST_DECIDE && !whisper_r && !early) begin
      if (prev_hit_r || slot_hit_r) begin
        act_session_r[wslot] <= ses_r; act_channel_r[wslot] <= ch_r;
        act_time_r[wslot] <= now_r; act_codec_r[wslot] <= codec_r;
        act_frame_r[wslot] <= frame_r; act_score_r[wslot] <= own;
        act_run_r[wslot] <= run_r; act_priority_r[wslot] <= prio_r;
      end
      if (s_hit || s_free_hit) begin
        sess_id_r[sslot] <= ses_r; sess_cand_r[sslot] <= cand_n;
        sess_weak_r[sslot] <= weak_n; sess_rel_r[sslot] <= rel_n;
        sess_muted_r[sslot] <= muted_n;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_suppress = o_suppress_r;
  assign out_overlap_seen = (o_count_r != 5'd0);
  assign out_overlap_count = o_count_r;
  assign out_has_details = o_details_r;
  assign out_kept_session = o_kept_ses_r;
  assign out_kept_score = o_kept_sc_r;
  assign out_own_score = o_own_r;
  assign out_gate_triggered = o_gate_r;
  assign out_table_full = o_full_r;

  // a drop without details would hide the rival
  a_sup_details: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_suppress || out_has_details)) else $error("suppress without details");
  a_gate_sup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gate_triggered |-> out_suppress) else $error("gate without suppress");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("ready while busy");
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// tb: self-checking bench for duplicate_stream_suppressor_core
// depends on dss_pkg and the core rtl; carries its own decision predictor
module tb;
  import dss_pkg::*;

  localparam int ACT_N = 16;
  localparam int SES_N = 16;
  localparam logic [16:0] RUN_WEIGHT = 17'd4;

  typedef struct {
    logic [31:0] ses;
    logic [31:0] ch;
    logic [31:0] ts;
    logic [1:0]  codec;
    logic [11:0] size;
    logic [31:0] frame;
    logic        prio;
    logic        term;
    logic        whisper;
  } pkt_t;

  typedef struct {
    logic        suppress;
    logic        overlap_seen;
    logic [4:0]  overlap_count;
    logic        has_details;
    logic [31:0] kept_session;
    logic [16:0] kept_score;
    logic [16:0] own_score;
    logic        gate;
    logic        full;
  } verdict_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [31:0] in_session_id, in_channel_id, in_timestamp_ms, in_frame_number;
  logic [1:0]  in_codec;
  logic [11:0] in_payload_size;
  logic in_is_priority, in_is_terminator, in_is_whisper;
  logic out_valid, out_ready;
  logic out_suppress, out_overlap_seen, out_has_details, out_gate_triggered;
  logic out_table_full;
  logic [4:0]  out_overlap_count;
  logic [31:0] out_kept_session;
  logic [16:0] out_kept_score, out_own_score;
  logic cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  duplicate_stream_suppressor_core dut (.*);

  // predictor copy of the registers
  logic [15:0] win_ms, ratio_q88, delta_min;
  logic [7:0]  weak_need, rel_need;

  // predictor copy of the activity table
  logic        a_vld [ACT_N];
  logic [31:0] a_ses [ACT_N], a_ch [ACT_N], a_ts [ACT_N], a_frm [ACT_N];
  logic [1:0]  a_codec [ACT_N];
  logic [16:0] a_score [ACT_N];
  logic [3:0]  a_run [ACT_N];
  logic        a_prio [ACT_N];

  // predictor copy of the session hysteresis table
  logic        s_vld [SES_N];
  logic [31:0] s_id [SES_N], s_cand [SES_N];
  logic [7:0]  s_weak [SES_N], s_rel [SES_N];
  logic        s_muted [SES_N];

  verdict_t pending_verdicts[$];
  int errors, n_words, n_results, n_suppressed, n_gated, n_full;
  bit quiet;              // no random idling on either side
  int hold_cycles;        // receiver hold-off, counted down in the receiver process

  // stimulus pools
  logic [31:0] ses_pool [8];
  logic [31:0] ch_pool [3];
  logic [31:0] frm_of [8];
  logic [31:0] now_ms;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results still pending", pending_verdicts.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [7:0] bump(input logic [7:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + 8'd1;
  endfunction

  function automatic bit beats(input logic [16:0] hi, input logic [16:0] lo);
    longint unsigned lhs, rhs;
    lhs = longint'(hi) * 256;
    rhs = longint'(lo) * longint'(ratio_q88);
    return lhs >= rhs && 32'(hi) >= 32'(lo) + 32'(delta_min);
  endfunction

  function automatic verdict_t decide_packet(input pkt_t p);
    verdict_t r;
    int prev, best, s, slot, cnt;
    logic [31:0] cand;
    logic [7:0] weak_v, rel;
    logic muted, fc, tc, stronger;
    logic [3:0] run;
    logic [16:0] own;
    r = '{default: '0};
    if (p.whisper) return r;
    prev = -1;
    s = -1;
    for (int i = 0; i < ACT_N; i++)
      if (a_vld[i] && a_ch[i] == p.ch && a_ses[i] == p.ses && prev < 0) prev = i;
    for (int i = 0; i < SES_N; i++)
      if (s_vld[i] && s_id[i] == p.ses && s < 0) s = i;
    // end of stream frees both entries
    if (p.term || p.size == 0) begin
      if (prev >= 0) a_vld[prev] = 1'b0;
      if (s >= 0) s_vld[s] = 1'b0;
      return r;
    end
    // stale entries of this channel go first, future ones stay
    for (int i = 0; i < ACT_N; i++)
      if (a_vld[i] && a_ch[i] == p.ch && p.ts > a_ts[i] && p.ts - a_ts[i] > 32'(win_ms))
        a_vld[i] = 1'b0;
    prev = -1;
    for (int i = 0; i < ACT_N; i++)
      if (a_vld[i] && a_ch[i] == p.ch && a_ses[i] == p.ses && prev < 0) prev = i;
    run = 4'd1;
    if (prev >= 0) begin
      fc = p.frame > a_frm[prev] && p.frame - a_frm[prev] <= FRAME_GAP_MAX;
      tc = p.ts >= a_ts[prev] && p.ts - a_ts[prev] <= 32'(win_ms);
      if (fc || tc) run = (a_run[prev] >= RUN_CAP) ? 4'(RUN_CAP) : a_run[prev] + 4'd1;
    end
    own = 17'(p.size) + 17'(run) * RUN_WEIGHT + (p.prio ? PRIORITY_BONUS : 17'd0);
    // overlap scan, ties kept by lowest session id
    best = -1;
    cnt = 0;
    for (int i = 0; i < ACT_N; i++) begin
      if (!a_vld[i] || a_ch[i] != p.ch || a_ses[i] == p.ses) continue;
      if (p.ts < a_ts[i] || p.ts - a_ts[i] > 32'(win_ms)) continue;
      if (cnt < 31) cnt++;
      if (best < 0 || a_score[i] > a_score[best] ||
          (a_score[i] == a_score[best] && a_ses[i] < a_ses[best]))
        best = i;
    end
    if (s >= 0) begin
      cand = s_cand[s]; weak_v = s_weak[s]; rel = s_rel[s]; muted = s_muted[s];
    end else begin
      cand = '0; weak_v = '0; rel = '0; muted = 1'b0;
    end
    if (best >= 0 && !p.prio) begin
      stronger = a_prio[best] || (a_codec[best] == p.codec && beats(a_score[best], own));
      if (stronger) begin
        if (cand == a_ses[best]) weak_v = bump(weak_v);
        else begin
          cand = a_ses[best]; weak_v = 8'd1; muted = 1'b0;
        end
        rel = '0;
        if (weak_v >= weak_need) begin
          r.gate = 1'b1; muted = 1'b1; r.suppress = 1'b1;
        end
      end else if (muted && cand != 0) begin
        rel = bump(rel);
        if (rel < rel_need) r.suppress = 1'b1;
        else begin
          cand = '0; weak_v = '0; rel = '0; muted = 1'b0;
        end
      end else begin
        cand = '0; weak_v = '0; rel = '0; muted = 1'b0;
      end
      if (r.suppress || r.gate) begin
        r.has_details = 1'b1;
        r.kept_session = a_ses[best];
        r.kept_score = a_score[best];
      end
    end else if (muted) begin
      rel = bump(rel);
      if (rel >= rel_need) begin
        cand = '0; weak_v = '0; rel = '0; muted = 1'b0;
      end
    end else begin
      cand = '0; weak_v = '0; rel = '0; muted = 1'b0;
    end
    // session entry, a full table runs against a throwaway default
    if (s < 0) begin
      for (int i = 0; i < SES_N; i++)
        if (!s_vld[i] && s < 0) s = i;
      if (s >= 0) begin
        s_vld[s] = 1'b1; s_id[s] = p.ses;
      end else r.full = 1'b1;
    end
    if (s >= 0) begin
      s_cand[s] = cand; s_weak[s] = weak_v; s_rel[s] = rel; s_muted[s] = muted;
    end
    slot = prev;
    for (int i = 0; i < ACT_N; i++)
      if (!a_vld[i] && slot < 0) slot = i;
    if (slot >= 0) begin
      a_vld[slot] = 1'b1; a_ses[slot] = p.ses; a_ch[slot] = p.ch; a_ts[slot] = p.ts;
      a_codec[slot] = p.codec; a_frm[slot] = p.frame; a_score[slot] = own;
      a_run[slot] = run; a_prio[slot] = p.prio;
    end else r.full = 1'b1;
    r.overlap_seen = cnt > 0;
    r.overlap_count = 5'(cnt);
    r.own_score = own;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("[%0t] result %0d: %s got %0h want %0h", $realtime, n_results, field, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    verdict_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("[%0t] result with no word outstanding", $realtime);
      end else begin
        w = pending_verdicts.pop_front();
        if (out_suppress !== w.suppress) report_mismatch("suppress", out_suppress, w.suppress);
        if (out_overlap_seen !== w.overlap_seen)
          report_mismatch("overlap_seen", out_overlap_seen, w.overlap_seen);
        if (out_overlap_count !== w.overlap_count)
          report_mismatch("overlap_count", out_overlap_count, w.overlap_count);
        if (out_has_details !== w.has_details)
          report_mismatch("has_details", out_has_details, w.has_details);
        if (out_kept_session !== w.kept_session)
          report_mismatch("kept_session", out_kept_session, w.kept_session);
        if (out_kept_score !== w.kept_score)
          report_mismatch("kept_score", out_kept_score, w.kept_score);
        if (out_own_score !== w.own_score)
          report_mismatch("own_score", out_own_score, w.own_score);
        if (out_gate_triggered !== w.gate)
          report_mismatch("gate_triggered", out_gate_triggered, w.gate);
        if (out_table_full !== w.full)
          report_mismatch("table_full", out_table_full, w.full);
        n_suppressed += w.suppress;
        n_gated += w.gate;
        n_full += w.full;
      end
      n_results++;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else out_ready <= quiet || $urandom_range(99) >= 6;
    end
  end

  // valid stays high after acceptance unless a random pause lowers it; any caller that waits lowers it first
  task automatic send_packet(input pkt_t p);
    in_valid <= 1'b1;
    in_session_id <= p.ses; in_channel_id <= p.ch; in_timestamp_ms <= p.ts;
    in_codec <= p.codec; in_payload_size <= p.size; in_frame_number <= p.frame;
    in_is_priority <= p.prio; in_is_terminator <= p.term; in_is_whisper <= p.whisper;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_verdicts = {pending_verdicts, decide_packet(p)};
    n_words++;
    if (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // sender pause until every result is back, then let the sequencer settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] w, input logic [7:0] wk,
                              input logic [7:0] rl, input logic [15:0] ra,
                              input logic [15:0] de);
    logic [15:0] vals [5];
    logic [2:0] idx [5];
    vals = '{w, 16'(wk), 16'(rl), ra, de};
    idx = '{REG_OVERLAP_WINDOW, REG_WEAK_FRAMES, REG_RELEASE_FRAMES,
            REG_STRONGER_RATIO, REG_STRONGER_DELTA};
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    win_ms = w; weak_need = wk; rel_need = rl; ratio_q88 = ra; delta_min = de;
  endtask

  function automatic pkt_t mk(input logic [31:0] ses, input logic [31:0] ch,
                              input logic [31:0] ts, input logic [11:0] size,
                              input logic [31:0] frame);
    pkt_t p;
    p = '{ses: ses, ch: ch, ts: ts, codec: 2'd0, size: size, frame: frame,
          prio: 1'b0, term: 1'b0, whisper: 1'b0};
    return p;
  endfunction

  // mostly live streams from small pools, some noise with every field random, session ids odd
  function automatic pkt_t random_packet();
    pkt_t p;
    int k;
    k = $urandom_range(7);
    if ($urandom_range(99) < 10) begin
      p = mk($urandom() | 32'd1, $urandom(), $urandom(), 12'($urandom()), $urandom());
      p.codec = 2'($urandom());
      p.prio = 1'($urandom_range(1));
      p.term = 1'($urandom_range(1));
      p.whisper = 1'($urandom_range(1));
      return p;
    end
    if ($urandom_range(99) < 5) now_ms = now_ms - $urandom_range(1, 20);
    else now_ms = now_ms + $urandom_range(0, 25);
    frm_of[k] = frm_of[k] + (($urandom_range(99) < 8) ? $urandom_range(4, 9) : 1);
    p = mk(ses_pool[k], ch_pool[$urandom_range(99) < 70 ? 0 : $urandom_range(1, 2)],
           now_ms, ($urandom_range(99) < 80) ? 12'($urandom_range(40, 400)) :
           12'($urandom()), frm_of[k]);
    p.codec = ($urandom_range(99) < 85) ? 2'd0 : 2'($urandom());
    p.prio = $urandom_range(99) < 6;
    p.term = $urandom_range(99) < 4;
    p.whisper = $urandom_range(99) < 4;
    if ($urandom_range(99) < 3) p.size = '0;
    return p;
  endfunction

  task automatic test_special_words();
    pkt_t p;
    p = mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 12'hFFF, 32'hFFFF_FFFF);
    p.prio = 1'b1;
    p.codec = 2'd3;
    send_packet(p);
    p.whisper = 1'b1;
    send_packet(p);
    p.whisper = 1'b0;
    p.term = 1'b1;
    send_packet(p);
    p = mk(32'd1, 32'd0, 32'd0, 12'd0, 32'd0);
    send_packet(p);
    for (int c = 0; c < 4; c++) begin
      p = mk(32'd2 + c, 32'd0, 32'd5, 12'd1, 32'd1);
      p.codec = 2'(c);
      send_packet(p);
    end
  endtask

  // strong vs weak stream: mute after the weak count, release after the rival leaves
  task automatic test_hysteresis();
    pkt_t p;
    logic [31:0] t;
    t = 32'd1000;
    for (int f = 0; f < 6; f++) begin
      send_packet(mk(32'hA0, 32'd7, t, 12'd2000, 32'(f)));
      send_packet(mk(32'hB0, 32'd7, t + 1, 12'd100, 32'(f)));
      t += 10;
    end
    p = mk(32'hA0, 32'd7, t, 12'd2000, 32'd6);
    p.term = 1'b1;
    send_packet(p);
    for (int f = 6; f < 12; f++) begin
      send_packet(mk(32'hB0, 32'd7, t, 12'd100, 32'(f)));
      t += 10;
    end
    // equal scores: the lower session id is kept
    send_packet(mk(32'hC5, 32'd8, t, 12'd3000, 32'd0));
    send_packet(mk(32'hC3, 32'd8, t, 12'd3000, 32'd0));
    p = mk(32'hC9, 32'd8, t, 12'd10, 32'd0);
    p.codec = 2'd1;
    send_packet(p);
  endtask

  // more streams than either table holds in one channel
  task automatic test_table_overflow();
    pkt_t p;
    drain_results();
    for (int k = 0; k < 18; k++) send_packet(mk(32'h500 + k, 32'd99, 32'd5000, 12'd50, 32'd0));
    for (int k = 0; k < 18; k++) begin
      p = mk(32'h500 + k, 32'd99, 32'd5000, 12'd50, 32'd1);
      p.term = 1'b1;
      send_packet(p);
    end
  endtask

  // receiver holds off while words keep coming, so the core stalls its input
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int k = 0; k < 12; k++) send_packet(random_packet());
    drain_results();
  endtask

  task automatic test_random_phase(input logic [15:0] w, input logic [7:0] wk,
                                   input logic [7:0] rl, input logic [15:0] ra,
                                   input logic [15:0] de, input int count);
    drain_results();
    program_regs(w, wk, rl, ra, de);
    quiet = 1'b1;
    for (int k = 0; k < count; k++) begin
      if (k == count / 3) quiet = 1'b0;
      send_packet(random_packet());
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0; cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    in_session_id <= '0; in_channel_id <= '0; in_timestamp_ms <= '0; in_codec <= '0;
    in_payload_size <= '0; in_frame_number <= '0; in_is_priority <= 1'b0;
    in_is_terminator <= 1'b0; in_is_whisper <= 1'b0;
    errors = 0; n_words = 0; n_results = 0; quiet = 1'b0; hold_cycles = 0;
    win_ms = 16'd60; weak_need = 8'd3; rel_need = 8'd5; ratio_q88 = 16'd320; delta_min = 16'd16;
    for (int i = 0; i < ACT_N; i++) a_vld[i] = 1'b0;
    for (int i = 0; i < SES_N; i++) s_vld[i] = 1'b0;
    for (int i = 0; i < 8; i++) begin
      ses_pool[i] = (i < 4) ? 32'(i + 1) : ($urandom() | 32'd1);
      frm_of[i] = $urandom();
    end
    for (int i = 0; i < 3; i++) ch_pool[i] = $urandom();
    now_ms = $urandom_range(1000, 100000);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_words();
    test_hysteresis();
    test_table_overflow();
    test_random_phase(16'd60, 8'd3, 8'd5, 16'd320, 16'd16, 200);
    test_backpressure();
    test_random_phase(16'd0, 8'd1, 8'd1, 16'd0, 16'd0, 180);
    test_random_phase(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 180);
    test_random_phase(16'd30, 8'd2, 8'd3, 16'd256, 16'd0, 200);
    test_random_phase(16'd100, 8'd0, 8'd0, 16'd400, 16'd50, 200);
    test_random_phase(16'($urandom()), 8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                      16'($urandom_range(256, 512)), 16'($urandom_range(0, 64)), 200);
    drain_results();

    $display("covered %0d words over six register settings: %0d dropped, %0d gate hits,",
             n_words, n_suppressed, n_gated);
    $display("%0d table-full results, with stalls and hold-off on both sides", n_full);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
